[design/mtep_pkg.sv]
// ----------------------------------------------------------------------------
// MIDI track event parser - shared definitions
// Parse state, result record, status codes and stream packing widths.
// ----------------------------------------------------------------------------
package mtep_pkg;

    localparam int MAX_VLQ_BYTES = 4;
    localparam int VLQ_CNT_W     = 3;
    localparam int DELTA_W       = 28;
    localparam int TEMPO_W       = 24;
    localparam int IN_TDATA_W    = 8;
    localparam int OUT_TDATA_W   = 80;

    localparam logic [7:0] ST_SYSEX      = 8'hF0;
    localparam logic [7:0] ST_SYSEX_ESC  = 8'hF7;
    localparam logic [7:0] ST_META       = 8'hFF;
    localparam logic [7:0] ST_ONE_LO     = 8'hC0;
    localparam logic [7:0] ST_ONE_HI     = 8'hDF;
    localparam logic [7:0] META_TEMPO    = 8'h51;
    localparam logic [7:0] META_EOT      = 8'h2F;

    typedef enum logic [6:0] {
        PH_DELTA     = 7'b0000001,
        PH_STATUS    = 7'b0000010,
        PH_DATA      = 7'b0000100,
        PH_META_TYPE = 7'b0001000,
        PH_META_LEN  = 7'b0010000,
        PH_SYSEX_LEN = 7'b0100000,
        PH_SKIP      = 7'b1000000
    } t_phase;

    typedef enum logic [1:0] {
        EV_CHANNEL = 2'd0,
        EV_TEMPO   = 2'd1,
        EV_EOT     = 2'd2,
        EV_ERROR   = 2'd3
    } t_kind;

    typedef struct packed {
        t_phase                 phase;
        logic [DELTA_W-1:0]     delta_acc;
        logic [VLQ_CNT_W-1:0]   vlq_cnt;
        logic [7:0]             running;
        logic [7:0]             current;
        logic [6:0]             held;
        logic [1:0]             needed;
        logic [7:0]             meta_type;
        logic [DELTA_W-1:0]     skip_len;
        logic [TEMPO_W-1:0]     tempo_acc;
        logic                   used_running;
    } t_state;

    localparam t_state STATE_RESET = '{
        phase:        PH_DELTA,
        delta_acc:    '0,
        vlq_cnt:      '0,
        running:      '0,
        current:      '0,
        held:         '0,
        needed:       '0,
        meta_type:    '0,
        skip_len:     '0,
        tempo_acc:    '0,
        used_running: 1'b0
    };

    typedef struct packed {
        t_kind                  kind;
        logic [DELTA_W-1:0]     delta_time;
        logic [7:0]             status_byte;
        logic [6:0]             first_data;
        logic [6:0]             second_data;
        logic [1:0]             data_count;
        logic                   used_running_status;
        logic                   truncated;
        logic [TEMPO_W-1:0]     tempo_value;
    } t_result;

endpackage

[design/mtep_step.sv]
// ----------------------------------------------------------------------------
// MIDI track event parser - byte step
// Next parse state and optional result for one track byte.
// ----------------------------------------------------------------------------
module mtep_step #(
    parameter int MAX_VLQ = mtep_pkg::MAX_VLQ_BYTES
) (
    input  mtep_pkg::t_state  i_state,
    input  logic [7:0]        i_data_byte,
    input  logic              i_track_start,
    output mtep_pkg::t_state  o_state,
    output logic              o_res_valid,
    output mtep_pkg::t_result o_res
);
    import mtep_pkg::*;

    function automatic logic [1:0] f_msg_size(input logic [7:0] st);
        return (st >= ST_ONE_LO && st <= ST_ONE_HI) ? 2'd1 : 2'd2;
    endfunction

    function automatic t_state f_to_delta(input t_state st);
        t_state t;
        t              = st;
        t.phase        = PH_DELTA;
        t.delta_acc    = '0;
        t.vlq_cnt      = '0;
        t.used_running = 1'b0;
        t.needed       = '0;
        t.held         = '0;
        return t;
    endfunction

    function automatic t_state f_start(input t_state st, input logic [7:0] b);
        t_state t;
        t              = st;
        t.used_running = 1'b0;
        t.vlq_cnt      = '0;
        t.skip_len     = '0;
        if (b < ST_SYSEX) begin
            t.running = b;
            t.current = b;
            t.held    = '0;
            t.needed  = f_msg_size(b);
            t.phase   = PH_DATA;
        end else if (b == ST_SYSEX || b == ST_SYSEX_ESC) begin
            t.current = b;
            t.phase   = PH_SYSEX_LEN;
        end else if (b == ST_META) begin
            t.current = b;
            t.phase   = PH_META_TYPE;
        end
        return t;
    endfunction

    t_state      s;
    t_state      n;
    t_result     res;
    logic        vld;
    logic        stray;
    logic [1:0]  total;
    logic [1:0]  got;
    logic        body_end;

    always_comb begin
        s     = i_track_start ? STATE_RESET : i_state;
        n     = s;
        res   = '0;
        vld   = 1'b0;
        body_end = 1'b0;
        stray = i_data_byte[7] && (i_data_byte >= ST_SYSEX) && (i_data_byte != ST_SYSEX)
                && (i_data_byte != ST_SYSEX_ESC) && (i_data_byte != ST_META);
        total = f_msg_size(s.current);
        got   = (s.needed <= total) ? total - s.needed : 2'd0;

        unique case (s.phase)
            PH_STATUS: begin
                if (i_data_byte[7]) begin
                    n = f_start(s, i_data_byte);
                    if (stray) begin
                        n               = f_to_delta(n);
                        vld             = 1'b1;
                        res.kind        = EV_ERROR;
                        res.delta_time  = s.delta_acc;
                        res.status_byte = i_data_byte;
                    end
                end else if (s.running == '0) begin
                    n              = f_to_delta(s);
                    vld            = 1'b1;
                    res.kind       = EV_ERROR;
                    res.delta_time = s.delta_acc;
                end else begin
                    n.current      = s.running;
                    n.used_running = 1'b1;
                    n.held         = i_data_byte[6:0];
                    n.needed       = f_msg_size(s.running) - 2'd1;
                    if (f_msg_size(s.running) == 2'd1) begin
                        n                       = f_to_delta(n);
                        vld                     = 1'b1;
                        res.kind                = EV_CHANNEL;
                        res.delta_time          = s.delta_acc;
                        res.status_byte         = s.running;
                        res.first_data          = i_data_byte[6:0];
                        res.data_count          = 2'd1;
                        res.used_running_status = 1'b1;
                    end else begin
                        n.phase = PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                vld                     = 1'b1;
                res.kind                = EV_CHANNEL;
                res.delta_time          = s.delta_acc;
                res.status_byte         = s.current;
                res.used_running_status = s.used_running;
                if (i_data_byte[7]) begin
                    n = f_start(f_to_delta(s), i_data_byte);
                    if (stray) begin
                        n = f_to_delta(n);
                    end
                    res.first_data = (got != 2'd0) ? s.held : 7'd0;
                    res.data_count = got;
                    res.truncated  = 1'b1;
                end else if (got == 2'd0) begin
                    n.held   = i_data_byte[6:0];
                    n.needed = total - 2'd1;
                    if (total == 2'd1) begin
                        n              = f_to_delta(n);
                        res.first_data = i_data_byte[6:0];
                        res.data_count = 2'd1;
                    end else begin
                        vld = 1'b0;
                    end
                end else begin
                    n               = f_to_delta(s);
                    res.first_data  = s.held;
                    res.second_data = i_data_byte[6:0];
                    res.data_count  = 2'd2;
                end
            end
            PH_META_TYPE: begin
                n.meta_type = i_data_byte;
                n.vlq_cnt   = '0;
                n.skip_len  = '0;
                n.phase     = PH_META_LEN;
            end
            PH_META_LEN, PH_SYSEX_LEN: begin
                if (s.vlq_cnt >= VLQ_CNT_W'(MAX_VLQ)) begin
                    n              = f_to_delta(s);
                    vld            = 1'b1;
                    res.kind       = EV_ERROR;
                    res.delta_time = s.delta_acc;
                end else begin
                    n.skip_len = {s.skip_len[DELTA_W-8:0], i_data_byte[6:0]};
                    n.vlq_cnt  = s.vlq_cnt + VLQ_CNT_W'(1);
                    if (!i_data_byte[7]) begin
                        n.vlq_cnt   = '0;
                        n.tempo_acc = '0;
                        if (n.skip_len == '0) begin
                            body_end = 1'b1;
                        end else begin
                            n.phase = PH_SKIP;
                        end
                    end
                end
            end
            PH_SKIP: begin
                n.tempo_acc = {s.tempo_acc[TEMPO_W-9:0], i_data_byte};
                n.skip_len  = s.skip_len - DELTA_W'(1);
                body_end    = (n.skip_len == '0);
            end
            PH_DELTA: begin
                if (s.vlq_cnt >= VLQ_CNT_W'(MAX_VLQ)) begin
                    n              = f_to_delta(s);
                    vld            = 1'b1;
                    res.kind       = EV_ERROR;
                    res.delta_time = s.delta_acc;
                end else begin
                    n.delta_acc = {s.delta_acc[DELTA_W-8:0], i_data_byte[6:0]};
                    n.vlq_cnt   = s.vlq_cnt + VLQ_CNT_W'(1);
                    if (!i_data_byte[7]) begin
                        n.vlq_cnt = '0;
                        n.phase   = PH_STATUS;
                    end
                end
            end
            default: begin
                n = f_to_delta(s);
            end
        endcase

        // end of a sysex or meta body
        if (body_end) begin
            if (n.current == ST_META && n.meta_type == META_TEMPO) begin
                vld             = 1'b1;
                res.kind        = EV_TEMPO;
                res.delta_time  = n.delta_acc;
                res.tempo_value = n.tempo_acc;
            end else if (n.current == ST_META && n.meta_type == META_EOT) begin
                vld            = 1'b1;
                res.kind       = EV_EOT;
                res.delta_time = n.delta_acc;
            end
            n = f_to_delta(n);
        end
    end

    assign o_state     = n;
    assign o_res_valid = vld;
    assign o_res       = res;

endmodule

[design/midi_track_event_parser.sv]
// A result is registered after the byte that completes it leaves the input register.
// One track byte per cycle while the result register is free or draining; bytes that
// finish no event give no result. The parse state advances once per byte, set by the
// combinational byte step. Reset (synchronous, i_rst_n low) empties both stages,
// clears running status and returns the parser to waiting for a delta time.
// ----------------------------------------------------------------------------
// MIDI track event parser - top level
// Input register, byte step and result register on stream handshakes.
// ----------------------------------------------------------------------------
module midi_track_event_parser #(
    parameter int MAX_VLQ = mtep_pkg::MAX_VLQ_BYTES
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [mtep_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // [7:0] data_byte
    input  logic                              s_axis_tuser,  // [0] track_start
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [27:0] delta_time, [35:28] status_byte, [42:36] first_data,
    // [49:43] second_data, [51:50] data_count, [52] used_running_status,
    // [53] truncated, [77:54] tempo_value, [79:78] zero
    output logic [mtep_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    output logic [1:0]                        m_axis_tuser   // [1:0] event_kind
);
    import mtep_pkg::*;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_start;
    t_state      r_state;
    t_state      n_state;
    logic        r_out_valid;
    t_result     r_out;
    t_result     n_res;
    logic        n_res_valid;
    logic        advance;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    mtep_step #(
        .MAX_VLQ (MAX_VLQ)
    ) u_step (
        .i_state       (r_state),
        .i_data_byte   (r_in_byte),
        .i_track_start (r_in_start),
        .o_state       (n_state),
        .o_res_valid   (n_res_valid),
        .o_res         (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte  <= s_axis_tdata;
            r_in_start <= s_axis_tuser;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (m_axis_tready || !r_out_valid) begin
            r_out_valid <= advance && n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && n_res_valid) begin
            r_out <= n_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tdata  = {2'b00, r_out.tempo_value, r_out.truncated,
                            r_out.used_running_status, r_out.data_count,
                            r_out.second_data, r_out.first_data,
                            r_out.status_byte, r_out.delta_time};

    a_vlq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.vlq_cnt <= VLQ_CNT_W'(MAX_VLQ))
        else $error("quantity byte count beyond limit");

    a_data_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == PH_DATA) |-> (r_state.current[7] && r_state.current < ST_SYSEX
                                        && r_state.needed != 2'd0))
        else $error("collecting data without a channel status");

    a_meta_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind != EV_CHANNEL) |->
            (r_out.data_count == 2'd0 && !r_out.truncated && !r_out.used_running_status))
        else $error("non-channel result carries message fields");

    a_trunc_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.truncated) |-> (r_out.data_count != 2'd2))
        else $error("truncated message with full data");

    a_tempo_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind != EV_TEMPO) |-> (r_out.tempo_value == '0))
        else $error("tempo value on a non-tempo result");

endmodule

[tb/sv/midi_event_checker.sv]
// ----------------------------------------------------------------------------
// MIDI track event parser - result checker
// Follows every byte the parser accepts, works out the event it must report
// and compares each reported event with the oldest one still owed.
// ----------------------------------------------------------------------------
module midi_event_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    input  logic                             i_s_tready,
    input  logic [mtep_pkg::IN_TDATA_W-1:0]  i_s_tdata,   // [7:0] data_byte
    input  logic                             i_s_tuser,   // [0] track_start
    input  logic                             i_m_tvalid,
    input  logic                             i_m_tready,
    // [27:0] delta_time, [35:28] status_byte, [42:36] first_data,
    // [49:43] second_data, [51:50] data_count, [52] used_running_status,
    // [53] truncated, [77:54] tempo_value, [79:78] zero
    input  logic [mtep_pkg::OUT_TDATA_W-1:0] i_m_tdata,
    input  logic [1:0]                       i_m_tuser,   // [1:0] event_kind
    output int                               o_fail_count,
    output int                               o_pending
);
    import mtep_pkg::*;

    t_phase              phase;
    logic [DELTA_W-1:0]  delta_acc;
    logic [DELTA_W-1:0]  skip_len;
    logic [2:0]          vlq_cnt;
    logic [7:0]          running_st;
    logic [7:0]          cur_st;
    logic [7:0]          meta_kind;
    logic [6:0]          first_held;
    logic [1:0]          still_needed;
    logic [TEMPO_W-1:0]  tempo_acc;
    logic                from_running;

    t_result             owed_events[$];
    int                  fails;

    function automatic logic [1:0] msg_bytes(input logic [7:0] st);
        return (st >= ST_ONE_LO && st <= ST_ONE_HI) ? 2'd1 : 2'd2;
    endfunction

    function automatic t_result make_event(input t_kind kind, input logic [DELTA_W-1:0] dt,
                                           input logic [7:0] st, input logic [6:0] d1,
                                           input logic [6:0] d2, input logic [1:0] cnt,
                                           input logic rs, input logic tr,
                                           input logic [TEMPO_W-1:0] tempo);
        t_result r;
        r.kind                = kind;
        r.delta_time          = dt;
        r.status_byte         = st;
        r.first_data          = d1;
        r.second_data         = d2;
        r.data_count          = cnt;
        r.used_running_status = rs;
        r.truncated           = tr;
        r.tempo_value         = tempo;
        return r;
    endfunction

    function automatic void back_to_delta();
        phase        = PH_DELTA;
        delta_acc    = '0;
        vlq_cnt      = '0;
        from_running = 1'b0;
        still_needed = '0;
        first_held   = '0;
    endfunction

    function automatic void clear_parser();
        back_to_delta();
        running_st = '0;
        cur_st     = '0;
        meta_kind  = '0;
        skip_len   = '0;
        tempo_acc  = '0;
    endfunction

    // Sets up the event opened by status byte b; 1 when b is a stray status
    function automatic bit open_status(input logic [7:0] b);
        from_running = 1'b0;
        vlq_cnt      = '0;
        skip_len     = '0;
        if (b < ST_SYSEX) begin
            running_st   = b;
            cur_st       = b;
            first_held   = '0;
            still_needed = msg_bytes(b);
            phase        = PH_DATA;
            return 1'b0;
        end
        if (b == ST_SYSEX || b == ST_SYSEX_ESC) begin
            cur_st = b;
            phase  = PH_SYSEX_LEN;
            return 1'b0;
        end
        if (b == ST_META) begin
            cur_st = b;
            phase  = PH_META_TYPE;
            return 1'b0;
        end
        return 1'b1;
    endfunction

    // Sysex or meta body done: only tempo and end of track are reported
    function automatic bit close_body(output t_result r);
        logic [DELTA_W-1:0] dt;
        logic               is_meta;
        logic [7:0]         mt;
        logic [TEMPO_W-1:0] tv;
        dt      = delta_acc;
        is_meta = (cur_st == ST_META);
        mt      = meta_kind;
        tv      = tempo_acc;
        r       = '0;
        back_to_delta();
        if (is_meta && mt == META_TEMPO) begin
            r = make_event(EV_TEMPO, dt, 8'h00, 7'h00, 7'h00, 2'd0, 1'b0, 1'b0, tv);
            return 1'b1;
        end
        if (is_meta && mt == META_EOT) begin
            r = make_event(EV_EOT, dt, 8'h00, 7'h00, 7'h00, 2'd0, 1'b0, 1'b0, '0);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit parse_byte(input logic [7:0] b, input logic new_track,
                                      output t_result r);
        logic [1:0]         total;
        logic [1:0]         got;
        logic [DELTA_W-1:0] dt;
        t_result            cut;
        r = '0;
        if (new_track)
            clear_parser();
        dt = delta_acc;
        case (phase)
            PH_STATUS: begin
                if (b[7]) begin
                    if (open_status(b)) begin
                        back_to_delta();
                        r = make_event(EV_ERROR, dt, b, 7'h00, 7'h00, 2'd0, 1'b0, 1'b0, '0);
                        return 1'b1;
                    end
                    return 1'b0;
                end
                if (running_st == 8'h00) begin
                    back_to_delta();
                    r = make_event(EV_ERROR, dt, 8'h00, 7'h00, 7'h00, 2'd0, 1'b0, 1'b0, '0);
                    return 1'b1;
                end
                cur_st       = running_st;
                from_running = 1'b1;
                first_held   = b[6:0];
                still_needed = msg_bytes(cur_st) - 2'd1;
                if (still_needed == 2'd0) begin
                    r = make_event(EV_CHANNEL, dt, cur_st, b[6:0], 7'h00, 2'd1, 1'b1, 1'b0, '0);
                    back_to_delta();
                    return 1'b1;
                end
                phase = PH_DATA;
                return 1'b0;
            end
            PH_DATA: begin
                total = msg_bytes(cur_st);
                got   = (still_needed <= total) ? total - still_needed : 2'd0;
                cut   = make_event(EV_CHANNEL, dt, cur_st, (got != 2'd0) ? first_held : 7'h00,
                                   7'h00, got, from_running, 1'b1, '0);
                if (b[7]) begin
                    // early status: report what was gathered, b opens the next event
                    back_to_delta();
                    if (open_status(b))
                        back_to_delta();
                    r = cut;
                    return 1'b1;
                end
                if (got == 2'd0) begin
                    first_held   = b[6:0];
                    still_needed = total - 2'd1;
                    if (still_needed == 2'd0) begin
                        r = make_event(EV_CHANNEL, dt, cur_st, b[6:0], 7'h00, 2'd1,
                                       from_running, 1'b0, '0);
                        back_to_delta();
                        return 1'b1;
                    end
                    return 1'b0;
                end
                r = make_event(EV_CHANNEL, dt, cur_st, first_held, b[6:0], 2'd2,
                               from_running, 1'b0, '0);
                back_to_delta();
                return 1'b1;
            end
            PH_META_TYPE: begin
                meta_kind = b;
                vlq_cnt   = '0;
                skip_len  = '0;
                phase     = PH_META_LEN;
                return 1'b0;
            end
            PH_META_LEN, PH_SYSEX_LEN: begin
                if (vlq_cnt >= MAX_VLQ_BYTES) begin
                    back_to_delta();
                    r = make_event(EV_ERROR, dt, 8'h00, 7'h00, 7'h00, 2'd0, 1'b0, 1'b0, '0);
                    return 1'b1;
                end
                skip_len = {skip_len[DELTA_W-8:0], b[6:0]};
                vlq_cnt  = vlq_cnt + 3'd1;
                if (b[7])
                    return 1'b0;
                vlq_cnt   = '0;
                tempo_acc = '0;
                if (skip_len == '0)
                    return close_body(r);
                phase = PH_SKIP;
                return 1'b0;
            end
            PH_SKIP: begin
                tempo_acc = {tempo_acc[TEMPO_W-9:0], b};
                skip_len  = skip_len - 1'b1;
                if (skip_len == '0)
                    return close_body(r);
                return 1'b0;
            end
            default: begin
                if (vlq_cnt >= MAX_VLQ_BYTES) begin
                    back_to_delta();
                    r = make_event(EV_ERROR, dt, 8'h00, 7'h00, 7'h00, 2'd0, 1'b0, 1'b0, '0);
                    return 1'b1;
                end
                delta_acc = {delta_acc[DELTA_W-8:0], b[6:0]};
                vlq_cnt   = vlq_cnt + 3'd1;
                if (!b[7]) begin
                    vlq_cnt = '0;
                    phase   = PH_STATUS;
                end
                return 1'b0;
            end
        endcase
    endfunction

    task automatic check_field(input string fld, input logic [31:0] want, input logic [31:0] seen);
        if (want !== seen) begin
            fails = fails + 1;
            if (fails <= 10)
                $display("%m: %s mismatch, expected 0x%0h, got 0x%0h", fld, want, seen);
        end
    endtask

    always @(posedge i_clk) begin
        t_result due;
        t_result seen;
        if (!i_rst_n) begin
            clear_parser();
            owed_events.delete();
            fails = 0;
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                if (parse_byte(i_s_tdata, i_s_tuser, due))
                    owed_events.push_back(due);
            end
            if (i_m_tvalid && i_m_tready) begin
                seen.kind                = t_kind'(i_m_tuser);
                seen.delta_time          = i_m_tdata[27:0];
                seen.status_byte         = i_m_tdata[35:28];
                seen.first_data          = i_m_tdata[42:36];
                seen.second_data         = i_m_tdata[49:43];
                seen.data_count          = i_m_tdata[51:50];
                seen.used_running_status = i_m_tdata[52];
                seen.truncated           = i_m_tdata[53];
                seen.tempo_value         = i_m_tdata[77:54];
                if (owed_events.size() == 0) begin
                    fails = fails + 1;
                    if (fails <= 10)
                        $display("%m: unexpected event, kind %0d delta 0x%0h",
                                 seen.kind, seen.delta_time);
                end else begin
                    due = owed_events.pop_front();
                    check_field("event_kind", 32'(due.kind), 32'(seen.kind));
                    check_field("delta_time", 32'(due.delta_time), 32'(seen.delta_time));
                    check_field("status_byte", 32'(due.status_byte), 32'(seen.status_byte));
                    check_field("first_data", 32'(due.first_data), 32'(seen.first_data));
                    check_field("second_data", 32'(due.second_data), 32'(seen.second_data));
                    check_field("data_count", 32'(due.data_count), 32'(seen.data_count));
                    check_field("used_running_status", 32'(due.used_running_status),
                                32'(seen.used_running_status));
                    check_field("truncated", 32'(due.truncated), 32'(seen.truncated));
                    check_field("tempo_value", 32'(due.tempo_value), 32'(seen.tempo_value));
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= owed_events.size();
    end

endmodule

[tb/sv/tb_midi_track_event_parser.sv]
// ----------------------------------------------------------------------------
// MIDI track event parser - testbench top
// Feeds hand-picked and random track byte streams in bursts, with a stalling
// event sink, and reports the verdict from the checker's mismatch and pending counts.
// ----------------------------------------------------------------------------
module tb_midi_track_event_parser;
    import mtep_pkg::*;

    localparam int TRACK_LEN  = 1385;
    localparam int PAUSE_AT   = 900;
    localparam int HOLD_AT    = 500;
    localparam int HOLD_TICKS = 300;

    typedef struct packed {
        logic       first;
        logic [7:0] value;
    } t_track_byte;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_MOSTLY,
        RX_PULSE
    } t_rx_mode;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // [7:0] data_byte
    logic                   s_axis_tuser;   // [0] track_start
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // delta, status, data, flags, tempo
    logic [1:0]             m_axis_tuser;   // [1:0] event_kind

    int                     fail_count;
    int                     pending;
    int                     sent;
    bit                     hold_done;
    t_track_byte            track_bytes[$];
    logic [7:0]             last_channel;
    bit                     no_delta;

    midi_track_event_parser u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    midi_event_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic void add_byte(input logic [7:0] v, input logic first = 1'b0);
        t_track_byte tb;
        tb.first = first;
        tb.value = v;
        track_bytes.push_back(tb);
    endfunction

    function automatic logic [6:0] rand7();
        return 7'($urandom_range(0, 127));
    endfunction

    function automatic int data_len(input logic [7:0] st);
        return (st >= ST_ONE_LO && st <= ST_ONE_HI) ? 1 : 2;
    endfunction

    function automatic void add_vlq(input int unsigned len);
        logic [6:0] groups [4];
        int         n;
        n = 0;
        do begin
            groups[n] = len[6:0];
            len       = len >> 7;
            n         = n + 1;
        end while (len != 0 && n < 4);
        // padded form with a leading zero group is still legal
        if (n < 3 && $urandom_range(0, 9) == 0)
            add_byte(8'h80);
        for (int i = n - 1; i >= 0; i--)
            add_byte({i != 0, groups[i]});
    endfunction

    function automatic void add_body(input int n);
        repeat (n) add_byte(8'($urandom_range(0, 255)));
    endfunction

    function automatic void add_delta(input logic first);
        int n;
        n = ($urandom_range(0, 2) != 0) ? 1 : $urandom_range(2, 4);
        for (int i = 0; i < n; i++)
            add_byte({i < n - 1, rand7()}, first && i == 0);
    endfunction

    function automatic void build_directed();
        // new track, note with the data extremes
        add_byte(8'h00, 1'b1); add_byte(8'h90); add_byte(8'h00); add_byte(8'h7F);
        // longest delta, then a one-byte message
        add_byte(8'hFF); add_byte(8'hFF); add_byte(8'hFF); add_byte(8'h7F);
        add_byte(8'hC0); add_byte(8'h7F);
        // fifth delta byte
        repeat (5) add_byte(8'h80);
        // stray status
        add_byte(8'h00); add_byte(8'hF3);
        // pitch bend cut short by a sysex of zero length
        add_byte(8'h00); add_byte(8'hE0); add_byte(8'h3C); add_byte(ST_SYSEX); add_byte(8'h00);
        // tempo at its maximum
        add_byte(8'h00); add_byte(ST_META); add_byte(META_TEMPO); add_byte(8'h03);
        repeat (3) add_byte(8'hFF);
        add_byte(8'h00); add_byte(ST_META); add_byte(META_EOT); add_byte(8'h00);
        // new track, data byte with no running status
        add_byte(8'h00, 1'b1); add_byte(8'h40);
        last_channel = 8'h00;
    endfunction

    function automatic void add_event();
        int         pick;
        int         len;
        logic [7:0] st;
        logic       fresh;
        if (!no_delta) begin
            fresh = ($urandom_range(0, 99) < 3);
            if (fresh)
                last_channel = 8'h00;
            if ($urandom_range(0, 99) < 2) begin
                // overlong delta; the fifth byte is thrown away
                add_byte({1'b1, rand7()}, fresh);
                repeat (3) add_byte({1'b1, rand7()});
                add_byte(8'($urandom_range(0, 255)));
                return;
            end
            add_delta(fresh);
        end
        pick = $urandom_range(0, 99);
        if (no_delta && (pick >= 40 && pick < 62 || pick >= 91))
            pick = 0;
        no_delta = 1'b0;
        if (pick < 40) begin
            st = 8'($urandom_range(8'h80, 8'hEF));
            add_byte(st);
            repeat (data_len(st)) add_byte({1'b0, rand7()});
            last_channel = st;
        end else if (pick < 62) begin
            repeat ((last_channel == 8'h00) ? 1 : data_len(last_channel))
                add_byte({1'b0, rand7()});
        end else if (pick < 70) begin
            len = ($urandom_range(0, 3) != 0) ? 3 : $urandom_range(0, 6);
            add_byte(ST_META); add_byte(META_TEMPO); add_vlq(len); add_body(len);
        end else if (pick < 75) begin
            len = ($urandom_range(0, 3) != 0) ? 0 : $urandom_range(1, 3);
            add_byte(ST_META); add_byte(META_EOT); add_vlq(len); add_body(len);
        end else if (pick < 81) begin
            len = ($urandom_range(0, 29) == 0) ? $urandom_range(128, 300) : $urandom_range(0, 8);
            add_byte(ST_META); add_byte(8'($urandom_range(0, 255))); add_vlq(len); add_body(len);
        end else if (pick < 87) begin
            len = $urandom_range(0, 8);
            add_byte($urandom_range(0, 1) ? ST_SYSEX : ST_SYSEX_ESC); add_vlq(len); add_body(len);
        end else if (pick < 91) begin
            do st = 8'($urandom_range(8'hF1, 8'hFE)); while (st == ST_SYSEX_ESC);
            add_byte(st);
        end else if (pick < 96) begin
            // message cut short; the next event follows with no delta
            st = 8'($urandom_range(8'h80, 8'hEF));
            add_byte(st);
            if (data_len(st) == 2 && $urandom_range(0, 1))
                add_byte({1'b0, rand7()});
            last_channel = st;
            no_delta     = 1'b1;
        end else if (pick < 98) begin
            if ($urandom_range(0, 1)) begin
                add_byte(ST_META); add_byte(8'($urandom_range(0, 255)));
            end else begin
                add_byte(ST_SYSEX);
            end
            repeat (4) add_byte({1'b1, rand7()});
            add_byte(8'($urandom_range(0, 255)));
        end else begin
            add_body($urandom_range(1, 3));
        end
    endfunction

    // byte source
    initial begin
        int burst;
        int gap;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        sent          = 0;
        no_delta      = 1'b0;
        build_directed();
        while (track_bytes.size() < TRACK_LEN)
            add_event();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        burst = 0;
        for (int k = 0; k < track_bytes.size(); k++) begin
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= track_bytes[k].value;
            s_axis_tuser  <= track_bytes[k].first;
            do @(posedge i_clk); while (!s_axis_tready);
            sent = sent + 1;
            if (k == track_bytes.size() - 1) begin
                s_axis_tvalid <= 1'b0;
            end else if (k == PAUSE_AT) begin
                s_axis_tvalid <= 1'b0;
                do @(posedge i_clk); while (pending != 0);
            end else begin
                burst = burst - 1;
                if (burst <= 0) begin
                    burst = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                        : $urandom_range(1, 16);
                    gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    if (gap > 0) begin
                        s_axis_tvalid <= 1'b0;
                        repeat (gap) @(posedge i_clk);
                    end
                end
            end
        end
        do @(posedge i_clk); while (pending != 0);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("tb_midi_track_event_parser: PASS");
        else
            $display("tb_midi_track_event_parser: FAIL");
        $finish;
    end

    // event sink
    initial begin
        t_rx_mode mode;
        int       span;
        int       tick;
        m_axis_tready = 1'b0;
        hold_done     = 1'b0;
        tick          = 0;
        forever begin
            mode = t_rx_mode'($urandom_range(0, 3));
            span = $urandom_range(20, 120);
            repeat (span) begin
                @(posedge i_clk);
                tick = tick + 1;
                if (!hold_done && sent >= HOLD_AT) begin
                    // long back-pressure so the parser fills and stalls its input
                    hold_done = 1'b1;
                    m_axis_tready <= 1'b0;
                    repeat (HOLD_TICKS) @(posedge i_clk);
                end
                case (mode)
                    RX_OPEN:   m_axis_tready <= 1'b1;
                    RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
                    RX_MOSTLY: m_axis_tready <= ($urandom_range(0, 9) != 0);
                    default:   m_axis_tready <= (tick % 5 < 2);
                endcase
            end
        end
    end

    initial begin
        #5000000;
        $display("tb_midi_track_event_parser: FAIL");
        $finish;
    end

endmodule
